>>> rtl/smvm_pkg.sv
// Shared constants and types for the sparse matrix-vector multiplier.
package smvm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COL_W = 10;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned OP_W = 2;
  localparam int unsigned VECTOR_DEPTH_DEF = 1024;

  localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0100_0000;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_NZ = 2'd1;
  localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

  typedef struct packed {
    logic start;
    logic take;
  } scl_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] sum;
    logic              sat;
  } scl_stat_t;

endpackage

>>> rtl/smvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module smvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/smvm_scale.sv
// Row sum scaling unit: magnitude, two-pass 32x32 multiply, round, saturate.
module smvm_scale
  import smvm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scl_ctrl_t                ctrl_i,
  input  logic [ACC_W-1:0]         acc_i,
  input  logic [DATA_W-1:0]        scale_i,
  output scl_stat_t                stat_o
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_LO   = 3'd1;
  localparam logic [2:0] U_HI   = 3'd2;
  localparam logic [2:0] U_RND  = 3'd3;
  localparam logic [2:0] U_FIN  = 3'd4;

  localparam logic [63:0] HALF = 64'h0000_8000_0000_0000;

  logic [2:0]        state_q, state_d;
  logic [ACC_W-1:0]  mag_q;
  logic [DATA_W-1:0] smag_q;
  logic              neg_q;
  logic [63:0]       plo_q, phi_q, t_q;
  logic [47:0]       q_q;
  logic [31:0]       mul_a;
  logic [63:0]       mul_p;
  logic [47:0]       lim;
  logic              sat;
  logic [31:0]       mag_res;

  assign mul_a = (state_q == U_LO) ? mag_q[31:0] : mag_q[63:32];
  assign mul_p = 64'(mul_a) * 64'(smag_q);

  assign lim     = neg_q ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
  assign sat     = q_q > lim;
  assign mag_res = sat ? lim[31:0] : q_q[31:0];

  assign stat_o.done = (state_q == U_FIN);
  assign stat_o.sat  = sat;
  assign stat_o.sum  = neg_q ? (~mag_res + 32'd1) : mag_res;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (ctrl_i.start) state_d = U_LO;
      U_LO:   state_d = U_HI;
      U_HI:   state_d = U_RND;
      U_RND:  state_d = U_FIN;
      U_FIN:  if (ctrl_i.take) state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && ctrl_i.start) begin
      mag_q  <= acc_i[ACC_W-1] ? (~acc_i + 64'd1) : acc_i;
      smag_q <= scale_i[DATA_W-1] ? (~scale_i + 32'd1) : scale_i;
      neg_q  <= acc_i[ACC_W-1] ^ scale_i[DATA_W-1];
    end
    if (state_q == U_LO) begin
      plo_q <= mul_p;
    end
    if (state_q == U_HI) begin
      phi_q <= mul_p;
      t_q   <= plo_q + HALF;
    end
    if (state_q == U_RND) begin
      q_q <= 48'((phi_q + (t_q >> 32)) >> 16);
    end
  end

endmodule

>>> rtl/sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix times dense vector multiplier.
//
//   channel  direction  handshake              payload
//   in       request    in_valid_i/in_stall_o  opcode, column_index, data_value, last_in_row
//   out      result     out_valid_o/out_stall_i row_index, row_sum, saturated
//   cfg      write      cfg_we_i               cfg_wdata_i (scale factor)
//
// Vector write and unused opcode: handled on acceptance. Nonzero: store read, multiply,
// accumulate. Row end: those steps for a closing nonzero, none for an empty row, then
// scaling by the shared 32x32 multiplier used twice, plus the wait while the output
// register stays stalled.
// The vector store has no clearing pass; its entries are undefined until written.
// One request is worked at a time; a result waits in the output register meanwhile.
module sparse_matrix_vector_multiply
  import smvm_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [COL_W-1:0]         column_index_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic                     last_in_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ROW_W-1:0]         row_index_o,
  output logic signed [DATA_W-1:0] row_sum_o,
  output logic                     saturated_o,
  input  logic                     cfg_we_i,
  input  logic [DATA_W-1:0]        cfg_wdata_i
);

  localparam int unsigned AW = $clog2(VECTOR_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [DATA_W-1:0]        scale_q;
  logic [ACC_W-1:0]         acc_q;
  logic [ROW_W-1:0]         row_cnt_q;
  logic signed [DATA_W-1:0] data_q;
  logic                     last_q;
  logic                     in_range_q;
  logic signed [ACC_W-1:0]  prod_q;
  logic                     out_valid_q;
  logic [ROW_W-1:0]         out_row_q;
  logic [DATA_W-1:0]        out_sum_q;
  logic                     out_sat_q;

  logic                     in_acc;
  logic                     in_range;
  logic [16:0]              col_ext;
  logic [AW-1:0]            addr;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] vec_val;
  logic                     out_free;
  logic                     emit;
  scl_ctrl_t                scl_ctrl;
  scl_stat_t                scl_stat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign col_ext    = 17'(column_index_i);
  assign in_range   = col_ext < 17'(VECTOR_DEPTH);
  assign addr       = col_ext[AW-1:0];

  smvm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && opcode_i == OP_WRITE && in_range),
    .waddr_i(addr),
    .wdata_i(data_value_i),
    .re_i   (in_acc && opcode_i == OP_NZ),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  assign vec_val = in_range_q ? signed'(rdata) : '0;

  assign out_free       = !out_valid_q || !out_stall_i;
  assign emit           = (state_q == ST_WAIT) && scl_stat.done && out_free;
  assign scl_ctrl.start = (state_q == ST_START);
  assign scl_ctrl.take  = emit;

  smvm_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scl_ctrl),
    .acc_i  (acc_q),
    .scale_i(scale_q),
    .stat_o (scl_stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && opcode_i == OP_NZ) begin
          state_d = ST_MUL;
        end else if (in_acc && opcode_i == OP_EMPTY) begin
          state_d = ST_START;
        end
      end
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last_q ? ST_START : ST_IDLE;
      ST_START: state_d = ST_WAIT;
      ST_WAIT:  if (emit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_q     <= SCALE_RESET;
      acc_q       <= '0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (in_acc && opcode_i == OP_WRITE) begin
        acc_q     <= '0;
        row_cnt_q <= '0;
      end else if (state_q == ST_ACC) begin
        acc_q <= acc_q + prod_q;
      end else if (emit) begin
        acc_q     <= '0;
        row_cnt_q <= row_cnt_q + 16'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q     <= data_value_i;
      last_q     <= last_in_row_i;
      in_range_q <= in_range;
    end
    if (state_q == ST_MUL) begin
      prod_q <= vec_val * data_q;
    end
    if (emit) begin
      out_row_q <= row_cnt_q;
      out_sum_q <= scl_stat.sum;
      out_sat_q <= scl_stat.sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign row_sum_o   = signed'(out_sum_q);
  assign saturated_o = out_sat_q;

  a_row_end_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_NZ && last_in_row_i) |-> ##3 (state_q == ST_START))
    else $error("row end did not reach the scaling start");

  a_load_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WAIT))
    else $error("result loaded outside the wait state");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (acc_q == '0))
    else $error("accumulator not cleared on emission");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(row_cnt_q) |-> (row_cnt_q == $past(row_cnt_q) + 16'd1 || row_cnt_q == '0))
    else $error("row counter moved by other than one");

endmodule

>>> sim/sparse_matrix_vector_multiply_tb.sv
`timescale 1ns / 100ps
// Testbench for the sparse matrix-vector multiplier: directed table, then random matrices.
module sparse_matrix_vector_multiply_tb;
  import smvm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SEGMENTS = 12;
  localparam int unsigned SEGMENT_ITEMS = 146;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DIRECTED_ROWS = 23;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] data;
    logic              last;
  } request_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] sum;
    logic              sat;
  } row_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              typed;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] sum;
    logic              sat;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          opcode = OP_WRITE;
  logic [COL_W-1:0]         column_index = '0;
  logic signed [DATA_W-1:0] data_value = '0;
  logic                     last_in_row = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ROW_W-1:0]         row_index;
  logic signed [DATA_W-1:0] row_sum;
  logic                     saturated;
  logic                     cfg_we = 1'b0;
  logic [DATA_W-1:0]        cfg_wdata = '0;

  logic [DATA_W-1:0] vec_store [VECTOR_DEPTH_DEF];
  bit                col_written [VECTOR_DEPTH_DEF];
  logic [COL_W-1:0]  written_cols [$];
  logic [ACC_W-1:0]  row_acc = '0;
  logic [ROW_W-1:0]  row_count = '0;
  logic [DATA_W-1:0] scale_reg = SCALE_RESET;

  row_result_t pending_rows [$];
  request_t    stim_q [$];

  int fail_count = 0;
  int rows_checked = 0;
  int rows_saturated = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_EMPTY, 10'd0,   32'h0000_0000, 1'b0, 1'b1, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_WRITE, 10'd0,   32'h0100_0000, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_WRITE, 10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_WRITE, 10'd1,   32'h8000_0000, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_WRITE, 10'd2,   32'hFF00_0000, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_WRITE, 10'd3,   32'h0000_0001, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_NZ,    10'd0,   32'h0100_0000, 1'b1, 1'b1, 16'd0, 32'h0100_0000, 1'b0},
    '{OP_NZ,    10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'd1, 32'h7FFF_FFFF, 1'b1},
    '{OP_NZ,    10'd1,   32'h7FFF_FFFF, 1'b1, 1'b1, 16'd2, 32'h8000_0000, 1'b1},
    '{OP_NZ,    10'd1,   32'h8000_0000, 1'b1, 1'b1, 16'd3, 32'h7FFF_FFFF, 1'b1},
    '{OP_NZ,    10'd2,   32'h0000_0001, 1'b1, 1'b1, 16'd4, 32'hFFFF_FFFF, 1'b0},
    '{OP_NZ,    10'd3,   32'h0080_0000, 1'b1, 1'b1, 16'd5, 32'h0000_0001, 1'b0},
    '{OP_NZ,    10'd3,   32'hFF80_0000, 1'b1, 1'b1, 16'd6, 32'hFFFF_FFFF, 1'b0},
    '{OP_NZ,    10'd3,   32'h0040_0000, 1'b1, 1'b1, 16'd7, 32'h0000_0000, 1'b0},
    '{OP_NZ,    10'd0,   32'h1234_5678, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_NZ,    10'd2,   32'h00AB_CDEF, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_NZ,    10'd1023, 32'h0000_0100, 1'b1, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_UNUSED, 10'h155, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_NZ,    10'd0,   32'h0001_0000, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_EMPTY, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_WRITE, 10'h2AA, 32'h5A5A_5A5A, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_EMPTY, 10'h000, 32'h0000_0000, 1'b0, 1'b1, 16'd0, 32'h0000_0000, 1'b0},
    '{OP_NZ,    10'h2AA, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 32'h0000_0000, 1'b0}
  };

  logic [DATA_W-1:0] scale_plan [SEGMENTS] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0100_0000,
    32'hFF00_0000, 32'h0000_0001, 32'h0040_0000, 32'h0100_0000,
    32'hFFFF_FFFF, 32'h0000_8000, 32'hC000_0000, 32'h0100_0000
  };

  sparse_matrix_vector_multiply dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .column_index_i (column_index),
    .data_value_i   (data_value),
    .last_in_row_i  (last_in_row),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .row_index_o    (row_index),
    .row_sum_o      (row_sum),
    .saturated_o    (saturated),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void note_written(logic [COL_W-1:0] col);
    if (!col_written[col]) begin
      col_written[col] = 1'b1;
      written_cols.insert(written_cols.size(), col);
    end
  endfunction

  function automatic void add_request(request_t r);
    stim_q.insert(stim_q.size(), r);
  endfunction

  function automatic row_result_t finish_row();
    logic [ACC_W-1:0]  mag_acc;
    logic [DATA_W-1:0] mag_scale;
    logic [95:0]       prod;
    logic [95:0]       q;
    logic              neg;
    logic [DATA_W-1:0] lim;
    row_result_t       res;
    mag_acc = row_acc[ACC_W-1] ? -row_acc : row_acc;
    mag_scale = scale_reg[DATA_W-1] ? -scale_reg : scale_reg;
    prod = {32'd0, mag_acc} * {64'd0, mag_scale};
    q = (prod + (96'd1 << 47)) >> 48;
    neg = row_acc[ACC_W-1] ^ scale_reg[DATA_W-1];
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    res.row = row_count;
    res.sat = (q > {64'd0, lim});
    res.sum = res.sat ? lim : q[DATA_W-1:0];
    if (neg) begin
      res.sum = -res.sum;
    end
    row_acc = '0;
    row_count = row_count + 1'b1;
    return res;
  endfunction

  task automatic apply_request(input request_t r, output bit emits, output row_result_t res);
    logic signed [ACC_W-1:0] prod;
    emits = 1'b0;
    res = '0;
    case (r.op)
      OP_WRITE: begin
        vec_store[r.col] = r.data;
        note_written(r.col);
        row_acc = '0;
        row_count = '0;
      end
      OP_NZ: begin
        prod = $signed(vec_store[r.col]) * $signed(r.data);
        row_acc = row_acc + prod;
        if (r.last) begin
          res = finish_row();
          emits = 1'b1;
        end
      end
      OP_EMPTY: begin
        res = finish_row();
        emits = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  task automatic send_request(input request_t r, input bit use_typed,
                              input row_result_t typed_res);
    bit          emits;
    row_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= r.op;
    column_index <= r.col;
    data_value <= r.data;
    last_in_row <= r.last;
    do @(posedge clk); while (in_stall);
    apply_request(r, emits, res);
    if (emits) begin
      pending_rows.insert(pending_rows.size(), use_typed ? typed_res : res);
    end
    if (r.op != OP_UNUSED) begin
      requests_sent++;
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input logic [DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    scale_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      4, 5, 6, 7: v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hFFFF_FFFF;
          default: v = 32'h0100_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    return written_cols[$urandom_range(0, written_cols.size() - 1)];
  endfunction

  task automatic build_segment(input int target);
    int       made;
    int       kind;
    int       n;
    request_t r;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      if (written_cols.size() == 0 || kind < 8) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          r = '{OP_WRITE, COL_W'($urandom_range(0, VECTOR_DEPTH_DEF - 1)), pick_value(),
                1'($urandom_range(0, 1))};
          note_written(r.col);
          add_request(r);
          made++;
        end
      end else if (kind < 88) begin
        if ($urandom_range(0, 6) == 0) begin
          r = '{OP_EMPTY, COL_W'($urandom), $urandom, 1'($urandom_range(0, 1))};
          add_request(r);
          made++;
        end else begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            r = '{OP_NZ, pick_col(), pick_value(), i == n - 1};
            add_request(r);
            made++;
          end
        end
      end else if (kind < 94) begin
        r = '{OP_UNUSED, COL_W'($urandom), $urandom, 1'($urandom_range(0, 1))};
        add_request(r);
      end else begin
        // break a row off early, by an empty row or a vector write
        n = $urandom_range(1, 3);
        repeat (n) begin
          r = '{OP_NZ, pick_col(), pick_value(), 1'b0};
          add_request(r);
          made++;
        end
        if ($urandom_range(0, 1) == 0) begin
          r = '{OP_EMPTY, COL_W'($urandom), $urandom, 1'($urandom_range(0, 1))};
        end else begin
          r = '{OP_WRITE, COL_W'($urandom_range(0, VECTOR_DEPTH_DEF - 1)), pick_value(),
                1'b0};
          note_written(r.col);
        end
        add_request(r);
        made++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_rows
    row_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        note_failure($sformatf("unexpected row: row %0d sum %h sat %0b",
                               row_index, row_sum, saturated));
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (saturated === 1'b1) begin
          rows_saturated++;
        end
        if (row_index !== want.row || row_sum !== want.sum || saturated !== want.sat) begin
          note_failure($sformatf(
            "row mismatch: expected row %0d sum %h sat %0b, got row %0d sum %h sat %0b",
            want.row, want.sum, want.sat, row_index, row_sum, saturated));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    request_t    r;
    row_result_t typed_res;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 63;
    foreach (directed_rows[i]) begin
      r = '{directed_rows[i].op, directed_rows[i].col, directed_rows[i].data,
            directed_rows[i].last};
      typed_res = '{directed_rows[i].row, directed_rows[i].sum, directed_rows[i].sat};
      send_request(r, directed_rows[i].typed, typed_res);
    end
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      if (seg < 4) begin
        send_idle_pct = 25;
        recv_idle_pct = 63;
      end else if (seg < 8) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_scale((seg % 4 == 3) ? $urandom : scale_plan[seg]);
      build_segment(SEGMENT_ITEMS);
      while (stim_q.size() != 0) begin
        send_request(stim_q.pop_front(), 1'b0, '0);
      end
    end
    wait_idle();
    $display("%0d requests over %0d scale settings and three idling mixes", requests_sent,
             SEGMENTS + 1);
    $display("%0d row results checked, %0d of them saturated", rows_checked, rows_saturated);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/smvm_pkg.sv
rtl/smvm_ram.sv
rtl/smvm_scale.sv
rtl/sparse_matrix_vector_multiply.sv
sim/sparse_matrix_vector_multiply_tb.sv
